// ===== src/lcet_pkg.sv =====
`default_nettype none
package lcet_pkg;

  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned NODES_DEF  = 4096;

  localparam int unsigned SLOPE_W = 32;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned ICPT_W  = 64;
  localparam int unsigned SUM_W   = 65;
  localparam int unsigned LCNT_W  = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned OP_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_INSERT  = 3'd2,
    OP_QPOS    = 3'd3,
    OP_QCOORD  = 3'd4
  } op_e;

endpackage
`default_nettype wire

// ===== src/lcet_eval.sv =====
`default_nettype none
module lcet_eval
  import lcet_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic signed [SLOPE_W-1:0] m_i,
  input  wire logic signed [ICPT_W-1:0]  c_i,
  input  wire logic signed [COORD_W-1:0] x_i,
  output logic signed [SUM_W-1:0]        sum_o
);

  logic signed [SLOPE_W+COORD_W-1:0] prod_q;
  logic signed [ICPT_W-1:0]          c_q;
  logic signed [SUM_W-1:0]           sum_q;

  // The product and the intercept are registered, then their sum is registered.
  always_ff @(posedge clk_i) begin
    prod_q <= m_i * x_i;
    c_q    <= c_i;
    sum_q  <= SUM_W'(prod_q) + SUM_W'(c_q);
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

// ===== src/max_line_envelope_tree_core.sv =====
// Upper envelope of lines y = slope*x + intercept over a sorted coordinate table.
// Input words arrive on in_valid_i/in_stall_o; a word is taken when valid is high
// and stall is low. Results leave on out_valid_o/out_stall_i through an output
// register, so a finished answer may wait while the next word is taken.
// Only query position and query coordinate words produce a result word.
// The leaf count register is written on cfg_valid_i/cfg_ready_o; the user must
// write it only while idle, which the block does not enforce. One word is
// handled at a time; stall is high until it is finished. Load writes the
// coordinate table as the word is taken. Clear is a pass over the node memory.
// Insert walks the tree level by level: it reads the node, then makes up to
// three line comparisons on the single multiply-add unit. A position query reads
// the node and evaluates its line at each level, and a coordinate query first
// runs a binary search over the coordinate table. After reset the same clearing
// pass runs before the first word is taken. When the receiver stalls, a second
// result waits until the output register is free.
`default_nettype none
module max_line_envelope_tree_core
  import lcet_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF,
  parameter int unsigned NODES  = NODES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [OP_W-1:0]           operation_i,
  input  wire logic [POS_W-1:0]          position_i,
  input  wire logic signed [COORD_W-1:0] coordinate_i,
  input  wire logic signed [SLOPE_W-1:0] slope_i,
  input  wire logic signed [ICPT_W-1:0]  intercept_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           found_o,
  output logic signed [ICPT_W-1:0]       best_value_o,
  output logic                           saturated_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [LCNT_W-1:0]         cfg_leaf_count_i
);

  localparam int unsigned LW  = $clog2(LEAVES);
  localparam int unsigned CW  = (LW + 1 > LCNT_W) ? LW + 1 : LCNT_W;
  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned NDW = 1 + SLOPE_W + ICPT_W;

  typedef enum logic [18:0] {
    ST_CLR    = 19'h00001,
    ST_IDLE   = 19'h00002,
    ST_INS_RD = 19'h00004,
    ST_INS_ND = 19'h00008,
    ST_INS_X  = 19'h00010,
    ST_EVA    = 19'h00020,
    ST_EVB    = 19'h00040,
    ST_EVC    = 19'h00080,
    ST_EVD    = 19'h00100,
    ST_QP_X   = 19'h00200,
    ST_Q_XD   = 19'h00400,
    ST_Q_RD   = 19'h00800,
    ST_Q_ND   = 19'h01000,
    ST_Q_W1   = 19'h02000,
    ST_Q_W2   = 19'h04000,
    ST_B_CHK  = 19'h08000,
    ST_B_D    = 19'h10000,
    ST_B_E    = 19'h20000,
    ST_FIN    = 19'h40000
  } state_e;

  typedef enum logic [2:0] {
    PH_MID   = 3'b001,
    PH_LEFT  = 3'b010,
    PH_RIGHT = 3'b100
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [LCNT_W-1:0] leaf_q;
  logic [NW:0] clr_q, clr_d;
  logic out_valid_q, out_valid_d;

  logic [NW:0] node_q, node_d;
  logic [LW-1:0] l_q, l_d, r_q, r_d, idx_q, idx_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [SLOPE_W-1:0] m_q, m_d, ns_q, ns_d;
  logic signed [ICPT_W-1:0] c_q, c_d, nc_q, nc_d;
  logic signed [COORD_W-1:0] x_q, x_d, key_q, key_d;
  logic signed [SUM_W-1:0] a_q, a_d, best_q, best_d;
  logic any_q, any_d;
  logic found_q, found_d, sat_q, sat_d;
  logic signed [ICPT_W-1:0] val_q, val_d;

  logic [COORD_W-1:0] coord_mem [LEAVES];
  logic [NDW-1:0] node_mem [NODES];
  logic signed [COORD_W-1:0] coord_rd_q;
  logic [NDW-1:0] node_rd_q;
  logic [LW-1:0] coord_raddr;
  logic coord_we;
  logic [LW-1:0] coord_waddr;
  logic node_we;
  logic [NW-1:0] node_waddr;
  logic [NDW-1:0] node_wdata;

  logic signed [SLOPE_W-1:0] ev_m;
  logic signed [ICPT_W-1:0] ev_c;
  logic signed [SUM_W-1:0] ev_sum;

  logic [CW-1:0] sz;
  logic [LW:0] mid_w;
  logic [LW-1:0] mid;
  logic [CW:0] bmid_w;
  logic [16:0] pos_ext;
  logic accept;
  logic out_free;
  logic node_ok;

  assign sz = (32'(leaf_q) > 32'(LEAVES)) ? CW'(LEAVES) : CW'(leaf_q);
  assign mid_w = ((LW + 1)'(l_q) + (LW + 1)'(r_q)) >> 1;
  assign mid = mid_w[LW-1:0];
  assign bmid_w = ((CW + 1)'(lo_q) + (CW + 1)'(hi_q)) >> 1;
  assign pos_ext = 17'(position_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign node_ok = (32'(node_q) < 32'(NODES));
  assign cfg_ready_o = 1'b1;

  lcet_eval u_eval (
    .clk_i (clk_i),
    .m_i   (ev_m),
    .c_i   (ev_c),
    .x_i   (x_q),
    .sum_o (ev_sum)
  );

  always_comb begin
    ev_m = m_q;
    ev_c = c_q;
    case (state_q)
      ST_EVB: begin
        ev_m = ns_q;
        ev_c = nc_q;
      end
      ST_Q_ND: begin
        ev_m = node_rd_q[SLOPE_W+ICPT_W-1:ICPT_W];
        ev_c = node_rd_q[ICPT_W-1:0];
      end
      default: begin
        ev_m = m_q;
        ev_c = c_q;
      end
    endcase
  end

  always_comb begin
    coord_raddr = mid;
    case (state_q)
      ST_EVD:   coord_raddr = (phase_q == PH_MID) ? l_q : r_q;
      ST_QP_X:  coord_raddr = idx_q;
      ST_B_CHK: coord_raddr = (lo_q < hi_q) ? bmid_w[LW-1:0] : lo_q[LW-1:0];
      default:  coord_raddr = mid;
    endcase
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    clr_d = clr_q;
    out_valid_d = out_valid_q;
    node_d = node_q;
    l_d = l_q;
    r_d = r_q;
    idx_d = idx_q;
    lo_d = lo_q;
    hi_d = hi_q;
    m_d = m_q;
    c_d = c_q;
    ns_d = ns_q;
    nc_d = nc_q;
    x_d = x_q;
    key_d = key_q;
    a_d = a_q;
    best_d = best_q;
    any_d = any_q;
    found_d = found_q;
    sat_d = sat_q;
    val_d = val_q;
    coord_we = 1'b0;
    coord_waddr = pos_ext[LW-1:0];
    node_we = 1'b0;
    node_waddr = node_q[NW-1:0];
    node_wdata = {1'b1, m_q, c_q};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        node_we = 1'b1;
        node_waddr = clr_q[NW-1:0];
        node_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == 32'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          node_d = (NW + 1)'(1);
          l_d = '0;
          r_d = LW'(sz - 1'b1);
          any_d = 1'b0;
          m_d = slope_i;
          c_d = intercept_i;
          key_d = coordinate_i;
          case (operation_i)
            OP_LOAD: begin
              if (32'(pos_ext) < 32'(LEAVES)) begin
                coord_we = 1'b1;
              end
            end
            OP_CLEAR: begin
              clr_d = '0;
              state_d = ST_CLR;
            end
            OP_INSERT: begin
              if (sz != '0) begin
                state_d = ST_INS_RD;
              end
            end
            OP_QPOS: begin
              idx_d = pos_ext[LW-1:0];
              state_d = (pos_ext < 17'(sz)) ? ST_QP_X : ST_FIN;
            end
            OP_QCOORD: begin
              lo_d = '0;
              hi_d = sz;
              state_d = ST_B_CHK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD: begin
        state_d = node_ok ? ST_INS_ND : ST_IDLE;
      end
      ST_INS_ND: begin
        if (!node_rd_q[NDW-1]) begin
          node_we = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ns_d = node_rd_q[SLOPE_W+ICPT_W-1:ICPT_W];
          nc_d = node_rd_q[ICPT_W-1:0];
          phase_d = PH_MID;
          state_d = ST_INS_X;
        end
      end
      ST_INS_X: begin
        x_d = coord_rd_q;
        state_d = ST_EVA;
      end
      ST_EVA: state_d = ST_EVB;
      ST_EVB: state_d = ST_EVC;
      ST_EVC: begin
        a_d = ev_sum;
        state_d = ST_EVD;
      end
      ST_EVD: begin
        case (phase_q)
          PH_MID: begin
            if (a_q > ev_sum) begin
              node_we = 1'b1;
              m_d = ns_q;
              c_d = nc_q;
              ns_d = m_q;
              nc_d = c_q;
            end
            if (l_q == r_q) begin
              state_d = ST_IDLE;
            end else begin
              phase_d = PH_LEFT;
              state_d = ST_INS_X;
            end
          end
          PH_LEFT: begin
            if (a_q > ev_sum) begin
              node_d = node_q << 1;
              r_d = mid;
              state_d = ST_INS_RD;
            end else begin
              phase_d = PH_RIGHT;
              state_d = ST_INS_X;
            end
          end
          default: begin
            if (a_q > ev_sum) begin
              node_d = (node_q << 1) | (NW + 1)'(1);
              l_d = LW'(mid_w + 1'b1);
              state_d = ST_INS_RD;
            end else begin
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      ST_QP_X: state_d = ST_Q_XD;
      ST_Q_XD: begin
        x_d = coord_rd_q;
        state_d = ST_Q_RD;
      end
      ST_Q_RD: begin
        state_d = node_ok ? ST_Q_ND : ST_FIN;
      end
      ST_Q_ND: begin
        state_d = node_rd_q[NDW-1] ? ST_Q_W1 : ST_FIN;
      end
      ST_Q_W1: state_d = ST_Q_W2;
      ST_Q_W2: begin
        if (!any_q || (ev_sum > best_q)) begin
          best_d = ev_sum;
        end
        any_d = 1'b1;
        if (l_q == r_q) begin
          state_d = ST_FIN;
        end else if (idx_q <= mid) begin
          node_d = node_q << 1;
          r_d = mid;
          state_d = ST_Q_RD;
        end else begin
          node_d = (node_q << 1) | (NW + 1)'(1);
          l_d = LW'(mid_w + 1'b1);
          state_d = ST_Q_RD;
        end
      end
      ST_B_CHK: begin
        if (lo_q < hi_q) begin
          hi_d = CW'(bmid_w);
          state_d = ST_B_D;
        end else if (lo_q >= sz) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_B_E;
        end
      end
      ST_B_D: begin
        // The probe index was parked in hi; put back whichever bound moves.
        if (coord_rd_q < key_q) begin
          lo_d = CW'(hi_q + 1'b1);
          hi_d = hi_q;
          state_d = ST_B_CHK;
        end else begin
          state_d = ST_B_CHK;
        end
      end
      ST_B_E: begin
        if (coord_rd_q == key_q) begin
          idx_d = lo_q[LW-1:0];
          x_d = coord_rd_q;
          state_d = ST_Q_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d = any_q;
          if (!any_q) begin
            val_d = '0;
            sat_d = 1'b0;
          end else if (best_q[SUM_W-1] == best_q[SUM_W-2]) begin
            val_d = best_q[ICPT_W-1:0];
            sat_d = 1'b0;
          end else begin
            val_d = best_q[SUM_W-1] ? {1'b1, {(ICPT_W-1){1'b0}}} : {1'b0, {(ICPT_W-1){1'b1}}};
            sat_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The binary search keeps hi as the upper bound: a probe below the key
  // restores it after lo moves past the probe.
  logic [CW-1:0] hi_keep_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_B_CHK) begin
      hi_keep_q <= hi_q;
    end
  end

  logic [CW-1:0] hi_fix;
  always_comb begin
    hi_fix = hi_d;
    if (state_q == ST_B_D && coord_rd_q < key_q) begin
      hi_fix = hi_keep_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      phase_q <= PH_MID;
      clr_q <= '0;
      out_valid_q <= 1'b0;
      leaf_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        leaf_q <= cfg_leaf_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    l_q <= l_d;
    r_q <= r_d;
    idx_q <= idx_d;
    lo_q <= lo_d;
    hi_q <= hi_fix;
    m_q <= m_d;
    c_q <= c_d;
    ns_q <= ns_d;
    nc_q <= nc_d;
    x_q <= x_d;
    key_q <= key_d;
    a_q <= a_d;
    best_q <= best_d;
    any_q <= any_d;
    found_q <= found_d;
    sat_q <= sat_d;
    val_q <= val_d;
  end

  always_ff @(posedge clk_i) begin
    if (coord_we) begin
      coord_mem[coord_waddr] <= coordinate_i;
    end
    coord_rd_q <= coord_mem[coord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_q <= node_mem[node_q[NW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign found_o = found_q;
  assign best_value_o = val_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top
  import lcet_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEAVES = LEAVES_DEF;
  localparam int unsigned NODES = NODES_DEF;
  localparam int unsigned LOADED_LEAVES = 256;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = NODES + 200;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic found;
    logic signed [63:0] value;
    logic sat;
  } answer_t;

  typedef enum logic { ROW_WORD, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic signed [31:0] coord;
    logic signed [31:0] slope;
    logic signed [63:0] icpt;
    logic typed;
    answer_t answer;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] operation = '0;
  logic [POS_W-1:0] position = '0;
  logic signed [31:0] coordinate = '0;
  logic signed [31:0] slope = '0;
  logic signed [63:0] intercept = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic signed [63:0] best_value;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LCNT_W-1:0] cfg_leaf_count = '0;

  int unsigned send_idle_pct = 37;
  int unsigned recv_stall_pct = 76;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  logic signed [31:0] coord_table [LEAVES];
  logic signed [31:0] line_slope [NODES];
  logic signed [63:0] line_icpt [NODES];
  logic line_present [NODES];
  logic [LCNT_W-1:0] leaf_count_reg = '0;
  answer_t pending_answers [$];
  row_t directed [$];

  max_line_envelope_tree_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .position_i(position), .coordinate_i(coordinate),
    .slope_i(slope), .intercept_i(intercept),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .found_o(found), .best_value_o(best_value), .saturated_o(saturated),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_leaf_count_i(cfg_leaf_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result word", {found, saturated}, '0);
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (best_value !== want.value) report_mismatch("best_value", best_value, want.value);
        if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
      end
    end
  end

  function automatic logic signed [65:0] line_value(logic signed [31:0] m,
      logic signed [63:0] c, logic signed [31:0] x);
    logic signed [65:0] mm, xx, cc;
    mm = m;
    xx = x;
    cc = c;
    return mm * xx + cc;
  endfunction

  function automatic int unsigned leaves_in_use();
    return (leaf_count_reg > LEAVES) ? LEAVES : leaf_count_reg;
  endfunction

  function automatic void envelope_insert(logic signed [31:0] m, logic signed [63:0] c);
    int unsigned sz, node, l, r, mid;
    logic signed [31:0] tm;
    logic signed [63:0] tc;
    sz = leaves_in_use();
    if (sz == 0) return;
    node = 1;
    l = 0;
    r = sz - 1;
    forever begin
      if (node >= NODES) return;
      if (!line_present[node]) begin
        line_present[node] = 1'b1;
        line_slope[node] = m;
        line_icpt[node] = c;
        return;
      end
      mid = (l + r) >> 1;
      if (line_value(m, c, coord_table[mid]) >
          line_value(line_slope[node], line_icpt[node], coord_table[mid])) begin
        tm = line_slope[node];
        tc = line_icpt[node];
        line_slope[node] = m;
        line_icpt[node] = c;
        m = tm;
        c = tc;
      end
      if (l == r) return;
      if (line_value(m, c, coord_table[l]) >
          line_value(line_slope[node], line_icpt[node], coord_table[l])) begin
        node = node * 2;
        r = mid;
      end else if (line_value(m, c, coord_table[r]) >
          line_value(line_slope[node], line_icpt[node], coord_table[r])) begin
        node = node * 2 + 1;
        l = mid + 1;
      end else begin
        return;
      end
    end
  endfunction

  function automatic answer_t envelope_at_leaf(int unsigned idx);
    int unsigned sz, node, l, r, mid;
    logic any;
    logic signed [65:0] best, v;
    answer_t a;
    a = '0;
    sz = leaves_in_use();
    if (sz == 0 || idx >= sz) return a;
    node = 1;
    l = 0;
    r = sz - 1;
    any = 1'b0;
    best = '0;
    forever begin
      if (node >= NODES || !line_present[node]) break;
      v = line_value(line_slope[node], line_icpt[node], coord_table[idx]);
      if (!any || v > best) best = v;
      any = 1'b1;
      if (l == r) break;
      mid = (l + r) >> 1;
      if (idx <= mid) begin
        node = node * 2;
        r = mid;
      end else begin
        node = node * 2 + 1;
        l = mid + 1;
      end
    end
    if (!any) return a;
    a.found = 1'b1;
    if (best[65:63] == 3'b000 || best[65:63] == 3'b111) begin
      a.value = best[63:0];
    end else begin
      a.value = best[65] ? S64_MIN : S64_MAX;
      a.sat = 1'b1;
    end
    return a;
  endfunction

  function automatic answer_t envelope_at_coordinate(logic signed [31:0] x);
    int unsigned sz, lo, hi, mid;
    sz = leaves_in_use();
    lo = 0;
    hi = sz;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (coord_table[mid] < x) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= sz || coord_table[lo] != x) return '0;
    return envelope_at_leaf(lo);
  endfunction

  // Updates the predicted state for one accepted word and returns whether it answers.
  function automatic logic envelope_apply(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
      logic signed [31:0] x, logic signed [31:0] m, logic signed [63:0] c,
      output answer_t a);
    a = '0;
    case (op)
      OP_LOAD: coord_table[pos] = x;
      OP_CLEAR: foreach (line_present[i]) line_present[i] = 1'b0;
      OP_INSERT: envelope_insert(m, c);
      OP_QPOS: begin
        a = envelope_at_leaf(pos);
        return 1'b1;
      end
      OP_QCOORD: begin
        a = envelope_at_coordinate(x);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_word(row_t w);
    answer_t a;
    logic answers;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = w.op;
    position = w.pos;
    coordinate = w.coord;
    slope = w.slope;
    intercept = w.icpt;
    do @(posedge clk); while (in_stall);
    answers = envelope_apply(w.op, w.pos, w.coord, w.slope, w.icpt, a);
    if (answers) pending_answers = {pending_answers, (w.typed ? w.answer : a)};
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic write_leaf_count(logic [LCNT_W-1:0] n);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_leaf_count = n;
    do @(posedge clk); while (!cfg_ready);
    leaf_count_reg = n;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic row_t word_row(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
      logic signed [31:0] x, logic signed [31:0] m, logic signed [63:0] c);
    row_t w;
    w.kind = ROW_WORD;
    w.op = op;
    w.pos = pos;
    w.coord = x;
    w.slope = m;
    w.icpt = c;
    w.typed = 1'b0;
    w.answer = '0;
    return w;
  endfunction

  function automatic row_t typed_row(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
      logic signed [31:0] x, answer_t a);
    row_t w;
    w = word_row(op, pos, x, '0, '0);
    w.typed = 1'b1;
    w.answer = a;
    return w;
  endfunction

  function automatic row_t cfg_row(logic [LCNT_W-1:0] n);
    row_t w;
    w = word_row(OP_LOAD, '0, '0, '0, '0);
    w.kind = ROW_CFG;
    w.pos = n[POS_W-1:0];
    w.coord = n;
    return w;
  endfunction

  function automatic void add_row(row_t w);
    directed = {directed, w};
  endfunction

  function automatic row_t random_word(int unsigned sz);
    row_t w;
    int unsigned pick, idx;
    logic signed [31:0] m, x;
    logic signed [63:0] c;
    pick = $urandom_range(99);
    m = $urandom;
    c = {$urandom, $urandom};
    if ($urandom_range(9) == 0) m = $urandom_range(1) ? S32_MAX : S32_MIN;
    if ($urandom_range(9) == 0) c = $urandom_range(1) ? S64_MAX : S64_MIN;
    idx = $urandom_range(sz + 1);
    if (idx >= LEAVES) idx = LEAVES - 1;
    x = ($urandom_range(9) < 7) ? coord_table[idx] : $urandom;
    if (pick < 45) w = word_row(OP_INSERT, POS_W'($urandom), $urandom, m, c);
    else if (pick < 70) w = word_row(OP_QPOS,
                                     POS_W'(($urandom_range(9) < 8) ? idx : $urandom),
                                     $urandom, $urandom, {$urandom, $urandom});
    else if (pick < 92) w = word_row(OP_QCOORD, POS_W'($urandom), x, $urandom,
                                     {$urandom, $urandom});
    else if (pick < 95) w = word_row(OP_LOAD, POS_W'($urandom), $urandom, $urandom, c);
    else if (pick < 97) w = word_row(OP_CLEAR, POS_W'($urandom), $urandom, m, c);
    else w = word_row(3'($urandom_range(5, 7)), POS_W'($urandom), $urandom, m, c);
    return w;
  endfunction

  initial begin
    logic [LCNT_W-1:0] sizes [6];
    int unsigned sz;
    foreach (line_present[i]) line_present[i] = 1'b0;
    foreach (coord_table[i]) coord_table[i] = '0;

    add_row(typed_row(OP_QPOS, 10'd0, 32'sd0, '0));
    add_row(typed_row(OP_QCOORD, 10'd0, 32'sd0, '0));
    add_row(word_row(OP_INSERT, 10'd0, 32'sd0, S32_MAX, S64_MAX));
    add_row(typed_row(OP_QPOS, 10'd0, 32'sd0, '0));
    add_row(word_row(OP_LOAD, 10'd0, -32'sd10, '0, '0));
    add_row(word_row(OP_LOAD, 10'd1, 32'sd0, '0, '0));
    add_row(word_row(OP_LOAD, 10'd2, 32'sd5, '0, '0));
    add_row(word_row(OP_LOAD, 10'd3, 32'sd100, '0, '0));
    add_row(cfg_row(11'd4));
    add_row(word_row(OP_INSERT, 10'h3FF, S32_MIN, S32_MAX, S64_MAX));
    add_row(typed_row(OP_QPOS, 10'd3, 32'sd0, '{1'b1, S64_MAX, 1'b1}));
    add_row(typed_row(OP_QCOORD, 10'd0, 32'sd100, '{1'b1, S64_MAX, 1'b1}));
    add_row(typed_row(OP_QPOS, 10'd4, 32'sd0, '0));
    add_row(typed_row(OP_QCOORD, 10'd0, 32'sd7, '0));
    add_row(word_row(OP_CLEAR, 10'd0, 32'sd0, '0, '0));
    add_row(typed_row(OP_QPOS, 10'd0, 32'sd0, '0));
    add_row(word_row(OP_INSERT, 10'd0, 32'sd0, S32_MIN, S64_MIN));
    add_row(typed_row(OP_QPOS, 10'd3, 32'sd0, '{1'b1, S64_MIN, 1'b1}));
    add_row(word_row(OP_QPOS, 10'd0, 32'sd0, '0, '0));
    add_row(word_row(OP_INSERT, 10'd0, 32'sd0, 32'sd0, 64'sd5));
    add_row(word_row(OP_QCOORD, 10'd0, -32'sd10, '0, '0));
    add_row(word_row(3'd5, 10'd0, 32'sd0, '0, '0));
    add_row(word_row(3'd6, 10'd0, 32'sd0, '0, '0));
    add_row(word_row(3'd7, 10'd0, 32'sd0, '0, '0));
    add_row(word_row(OP_QPOS, 10'd2, 32'sd0, '0, '0));

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_leaf_count(directed[i].coord[LCNT_W-1:0]);
      else send_word(directed[i]);
    end

    // Sorted, distinct coordinates spread over the whole 32-bit range.
    for (int i = 0; i < LOADED_LEAVES; i++) begin
      send_word(word_row(OP_LOAD, POS_W'(i), 32'(64'sd0 - 64'sh8000_0000 + i * (1 << 24)
                         + $urandom_range((1 << 24) - 1)), '0, '0));
    end

    sizes = '{11'd1, 11'd256, 11'd2, 11'd200, 11'd13, 11'd37};
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 76 : 0;
      recv_stall_pct = (phase == 0) ? 76 : (phase == 1) ? 37 : 0;
      for (int s = 0; s < 2; s++) begin
        write_leaf_count(sizes[phase * 2 + s]);
        send_word(word_row(OP_CLEAR, '0, '0, '0, '0));
        sz = leaves_in_use();
        for (int n = 0; n < 135; n++) begin
          if (n == 67) drain();
          send_word(random_word(sz));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
